// ===== design/flf_pkg.sv =====
// ----------------------------------------------------------------------------
// flf_pkg
// Shared constants, codes and control structs of the queue/stack store with
// unique keys.
// ----------------------------------------------------------------------------
package flf_pkg;

    localparam int DEPTH = 16;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int KEY_W = 32;
    localparam int OCC_W = 5;
    localparam int REC_W = 2 * KEY_W;

    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_QUEUE = 2'd1;
    localparam logic [1:0] MODE_STACK = 2'd2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_DUP    = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_NOMODE = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic       load;
        logic       scan_clr;
        logic       scan_en;
        logic       pop_rd;
        logic       push_commit;
        logic       pop_commit;
        logic       out_load;
        logic [2:0] status;
    } flf_cmd_t;

    typedef struct packed {
        logic func;
        logic mode_ok;
        logic empty;
        logic full;
        logic scan_done;
        logic dup;
        logic out_free;
    } flf_sts_t;

    // Ring slot k places after head, wrapped at DEPTH.
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                              input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(k);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

endpackage

// ===== design/fifo_lifo_with_duplicate_check_top.sv =====
// ----------------------------------------------------------------------------
// fifo_lifo_with_duplicate_check_top
// Bounded record store that works as a queue or a stack with unique keys.
// ----------------------------------------------------------------------------
// The cfg channel writes the two-bit mode: 1 selects queue order, 2 selects
// stack order, and any other value rejects every transaction. Write it only
// while no transaction is in flight.
// Each input transaction is an insert (s_tuser low) or a remove (s_tuser
// high) and produces exactly one result transaction carrying a status code
// in m_tuser and the removed record plus the occupancy in m_tdata.
// An insert reads every stored identifier from the record RAM, one per
// cycle, to reject duplicates, stepping through the check, scan and
// finish states after capture. A remove steps through check, record read
// and finish, and a transaction rejected for a missing mode or an empty
// store goes from check straight to finish.
// s_tready is high again in the cycle after the result is loaded, even if
// the receiver has not taken it.
// If m_tready stays low, the finished result waits in the output register
// and the next transaction stalls before its commit until the register
// frees. Reset empties the store and clears the mode; stored records need
// no clearing.
// ----------------------------------------------------------------------------
module fifo_lifo_with_duplicate_check_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // item_id[31:0], plate[63:32]
    input  logic        s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_id[31:0], out_plate[63:32],
                                   // occupancy[68:64], zero[71:69]
    output logic [2:0]  m_tuser    // status[2:0]
);

    flf_pkg::flf_cmd_t cmd;
    flf_pkg::flf_sts_t sts;

    assign cfg_ready = 1'b1;

    flf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    flf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Transaction accepted while another one is in flight.");

    a_push_pop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push_commit && cmd.pop_commit))
        else $error("Insert and remove committed in the same cycle.");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != flf_pkg::ST_OK)) |-> (m_tdata[63:0] == 64'd0))
        else $error("Rejected transaction carries a nonzero record.");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[68:64] <= 5'(flf_pkg::DEPTH)))
        else $error("Reported occupancy exceeds the store depth.");
`endif

endmodule

// ===== design/flf_ram.sv =====
// ----------------------------------------------------------------------------
// flf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module flf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/flf_dp.sv =====
// ----------------------------------------------------------------------------
// flf_dp
// Datapath: mode register, captured input, ring pointers, record memory,
// identifier scan and the result register.
// ----------------------------------------------------------------------------
module flf_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_data,
    input  logic [63:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              m_tready,
    input  flf_pkg::flf_cmd_t cmd,
    output flf_pkg::flf_sts_t sts,
    output logic              m_tvalid,
    output logic [71:0]       m_tdata,
    output logic [2:0]        m_tuser
);

    logic [1:0]                    mode_reg;
    logic                          func_reg;
    logic [flf_pkg::KEY_W-1:0]     id_reg;
    logic [flf_pkg::KEY_W-1:0]     plate_reg;
    logic [flf_pkg::IW-1:0]        head_reg, head_next;
    logic [flf_pkg::CW-1:0]        count_reg, count_next;
    logic [flf_pkg::CW-1:0]        scan_k_reg;
    logic                          scan_pend_reg;
    logic                          dup_reg;
    logic                          out_valid_reg;
    logic [2:0]                    out_status_reg;
    logic [flf_pkg::KEY_W-1:0]     out_id_reg;
    logic [flf_pkg::KEY_W-1:0]     out_plate_reg;
    logic [flf_pkg::OCC_W-1:0]     out_occ_reg;

    logic                          mode_ok;
    logic                          scan_more;
    logic [flf_pkg::IW-1:0]        pop_slot;
    logic [flf_pkg::IW-1:0]        raddr;
    logic                          re;
    logic [flf_pkg::REC_W-1:0]     rdata;
    logic [flf_pkg::CW+flf_pkg::OCC_W-1:0] occ_ext;

    assign mode_ok   = (mode_reg == flf_pkg::MODE_QUEUE) ||
                       (mode_reg == flf_pkg::MODE_STACK);
    assign scan_more = scan_k_reg < count_reg;
    assign pop_slot  = (mode_reg == flf_pkg::MODE_QUEUE) ? head_reg :
                       flf_pkg::slot_of(head_reg, count_reg - flf_pkg::CNT_ONE);
    assign raddr     = cmd.pop_rd ? pop_slot : flf_pkg::slot_of(head_reg, scan_k_reg);
    assign re        = cmd.pop_rd || (cmd.scan_en && scan_more);

    flf_ram #(
        .WIDTH (flf_pkg::REC_W),
        .DEPTH (flf_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.push_commit),
        .waddr (flf_pkg::slot_of(head_reg, count_reg)),
        .wdata ({plate_reg, id_reg}),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.push_commit) begin
            count_next = count_reg + flf_pkg::CNT_ONE;
        end else if (cmd.pop_commit) begin
            count_next = count_reg - flf_pkg::CNT_ONE;
            if (mode_reg == flf_pkg::MODE_QUEUE) begin
                head_next = flf_pkg::slot_of(head_reg, flf_pkg::CNT_ONE);
            end
        end
    end

    assign occ_ext = {{flf_pkg::OCC_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= flf_pkg::MODE_NONE;
            head_reg      <= '0;
            count_reg     <= '0;
            scan_k_reg    <= '0;
            scan_pend_reg <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.scan_clr) begin
                scan_k_reg    <= '0;
                scan_pend_reg <= 1'b0;
                dup_reg       <= 1'b0;
            end else if (cmd.scan_en) begin
                if (scan_more) begin
                    scan_k_reg <= scan_k_reg + flf_pkg::CNT_ONE;
                end
                scan_pend_reg <= scan_more;
                if (scan_pend_reg && (rdata[flf_pkg::KEY_W-1:0] == id_reg)) begin
                    dup_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_tuser;
            id_reg    <= s_tdata[flf_pkg::KEY_W-1:0];
            plate_reg <= s_tdata[flf_pkg::REC_W-1:flf_pkg::KEY_W];
        end
        if (cmd.out_load) begin
            out_status_reg <= cmd.status;
            out_occ_reg    <= occ_ext[flf_pkg::OCC_W-1:0];
            if (cmd.pop_commit) begin
                out_id_reg    <= rdata[flf_pkg::KEY_W-1:0];
                out_plate_reg <= rdata[flf_pkg::REC_W-1:flf_pkg::KEY_W];
            end else begin
                out_id_reg    <= '0;
                out_plate_reg <= '0;
            end
        end
    end

    assign sts.func      = func_reg;
    assign sts.mode_ok   = mode_ok;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg >= flf_pkg::CNT_FULL);
    assign sts.scan_done = !scan_pend_reg && !scan_more;
    assign sts.dup       = dup_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_occ_reg, out_plate_reg, out_id_reg};

endmodule

// ===== design/flf_ctrl.sv =====
// ----------------------------------------------------------------------------
// flf_ctrl
// Controller: sequences capture, identifier scan, record read and commit of
// one transaction at a time.
// ----------------------------------------------------------------------------
module flf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  flf_pkg::flf_sts_t sts,
    output flf_pkg::flf_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_POPRD  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] status;
    logic       ok;

    always_comb begin
        if (!sts.mode_ok) begin
            status = flf_pkg::ST_NOMODE;
        end else if (sts.func == flf_pkg::FUNC_INSERT) begin
            if (sts.dup) begin
                status = flf_pkg::ST_DUP;
            end else if (sts.full) begin
                status = flf_pkg::ST_FULL;
            end else begin
                status = flf_pkg::ST_OK;
            end
        end else if (sts.empty) begin
            status = flf_pkg::ST_EMPTY;
        end else begin
            status = flf_pkg::ST_OK;
        end
    end

    assign ok = (status == flf_pkg::ST_OK);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = status;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.scan_clr = 1'b1;
                if (!sts.mode_ok) begin
                    state_next = S_FINISH;
                end else if (sts.func == flf_pkg::FUNC_INSERT) begin
                    state_next = S_SCAN;
                end else if (sts.empty) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_POPRD;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_FINISH;
                end
            end
            S_POPRD: begin
                cmd.pop_rd = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.push_commit = ok && (sts.func == flf_pkg::FUNC_INSERT);
                    cmd.pop_commit  = ok && (sts.func == flf_pkg::FUNC_REMOVE);
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
